FILE: hw/rtl/rsi_pkg.sv
`timescale 1ns / 1ps

package rsi_pkg;

   localparam int PERIOD_BITS   = 8;
   localparam int INDEX_BITS    = 14;
   localparam int SEEN_BITS     = 9;
   localparam int STEP_BITS     = 7;
   localparam int STRENGTH_BITS = 49;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
   localparam logic [SEEN_BITS-1:0]   SEEN_MAX     = 9'd511;
   localparam logic [INDEX_BITS-1:0]  FULL_SCALE   = 14'd10000;
   localparam logic [STEP_BITS-1:0]   RATIO_STEPS  = 7'd14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN_LOAD,
      ST_GAIN_DIV,
      ST_LOSS_LOAD,
      ST_LOSS_DIV,
      ST_SCALE,
      ST_RATIO_DIV,
      ST_RESP
   } rsi_state_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_BITS-1:0] steps;
   } rsi_div_ctl_type;

endpackage

FILE: hw/rtl/rsi_div.sv
`timescale 1ns / 1ps

module rsi_div #(
   parameter int REM_W = 41,
   parameter int QUO_W = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rsi_pkg::rsi_div_ctl_type ctl,
   input  logic [REM_W-1:0]         rem_init,
   input  logic [QUO_W-1:0]         quo_init,
   input  logic [REM_W-1:0]         den,
   output logic [QUO_W-1:0]         quo,
   output logic                     done
);
   import rsi_pkg::*;

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]     den_ff, den_in;
   logic [STEP_BITS-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_W:0] trial;
   logic [REM_W:0] trial_diff;
   logic           fits;

   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign fits       = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         rem_in   = rem_init;
         quo_in   = quo_init;
         den_in   = den;
         count_in = ctl.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff - STEP_BITS'(1);
         busy_in  = count_ff != STEP_BITS'(1);
         done_in  = count_ff == STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

FILE: hw/rtl/relative_strength_index_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_price, req_series_start
// rsp_      out        rsp_valid/stall    rsp_strength_index, rsp_index_valid
// csr_      in         csr_valid/ready    csr_data (smoothing period)
//
// Warm-up requests (series start, or fewer differences than the period) go straight to the response state.
// Averaging requests run on one shared radix-2 divider: two average divisions of
// PRICE_BITS+FRAC_BITS steps and, unless the loss average is zero, one 14-step ratio
// division, after both averages are right-shifted until they fit in STRENGTH_BITS.
// Reset is synchronous; the period returns to 14 and the next request opens a series.
// A new request is taken while an earlier response is still stalled at the output.

module relative_strength_index_top #(
   parameter int PRICE_BITS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [PRICE_BITS-1:0]            req_price,
   input  logic                             req_series_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rsi_pkg::INDEX_BITS-1:0]   rsp_strength_index,
   output logic                             rsp_index_valid,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsi_pkg::PERIOD_BITS-1:0]  csr_data
);
   import rsi_pkg::*;

   localparam int AVG_W  = PRICE_BITS + FRAC_BITS;
   localparam int NUM_W  = AVG_W + PERIOD_BITS;
   localparam int SCL_W  = (AVG_W < STRENGTH_BITS) ? AVG_W : STRENGTH_BITS;
   localparam int REM_W  = SCL_W + 1;
   localparam int PROD_W = SCL_W + INDEX_BITS;

   rsi_state_type state_ff, state_in;

   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PRICE_BITS-1:0]  prev_ff, prev_in;
   logic [SEEN_BITS-1:0]   seen_ff, seen_in;
   logic [AVG_W-1:0]       gain_avg_ff, gain_avg_in;
   logic [AVG_W-1:0]       loss_avg_ff, loss_avg_in;
   logic [PRICE_BITS-1:0]  gain_ff, gain_in;
   logic [PRICE_BITS-1:0]  loss_ff, loss_in;
   logic                   smooth_ff, smooth_in;
   logic [AVG_W-1:0]       sg_ff, sg_in;
   logic [AVG_W-1:0]       sl_ff, sl_in;
   logic [INDEX_BITS-1:0]  res_ff, res_in;
   logic                   resv_ff, resv_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_strength_ff, rsp_strength_in;
   logic                   rsp_index_valid_ff, rsp_index_valid_in;

   logic                   req_accept;
   logic                   rsp_load;
   logic                   first;
   logic [PERIOD_BITS-1:0] p;
   logic [PERIOD_BITS-1:0] pm1;
   logic [SEEN_BITS-1:0]   p_seen;
   logic                   up;
   logic [PRICE_BITS-1:0]  gain_new;
   logic [PRICE_BITS-1:0]  loss_new;
   logic [AVG_W-1:0]       avg_sel;
   logic [PRICE_BITS-1:0]  x_sel;
   logic [NUM_W-1:0]       num_wild;
   logic [NUM_W-1:0]       num_first;
   logic [NUM_W-1:0]       avg_num;
   logic [PROD_W-1:0]      prod;
   logic [REM_W-1:0]       den_sum;
   logic                   big;
   logic                   ratio;

   rsi_div_ctl_type        div_ctl;
   logic [REM_W-1:0]       div_rem_init;
   logic [AVG_W-1:0]       div_quo_init;
   logic [REM_W-1:0]       div_den;
   logic [AVG_W-1:0]       div_quo;
   logic                   div_done;

   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign first      = req_series_start || (seen_ff == '0);
   assign p          = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
   assign pm1        = p - PERIOD_BITS'(1);
   assign p_seen     = SEEN_BITS'(p);
   assign up         = req_price > prev_ff;
   assign gain_new   = up ? (req_price - prev_ff) : '0;
   assign loss_new   = up ? '0 : (prev_ff - req_price);

   assign avg_sel   = (state_ff == ST_LOSS_LOAD) ? loss_avg_ff : gain_avg_ff;
   assign x_sel     = (state_ff == ST_LOSS_LOAD) ? loss_ff : gain_ff;
   assign num_wild  = NUM_W'(avg_sel) * NUM_W'(pm1) + (NUM_W'(x_sel) << FRAC_BITS);
   assign num_first = NUM_W'(avg_sel + AVG_W'(x_sel)) << FRAC_BITS;
   assign avg_num   = smooth_ff ? num_wild : num_first;

   assign prod    = PROD_W'(sg_ff[SCL_W-1:0]) * PROD_W'(FULL_SCALE);
   assign den_sum = REM_W'(sg_ff[SCL_W-1:0]) + REM_W'(sl_ff[SCL_W-1:0]);
   assign big     = ((sg_ff | sl_ff) >> STRENGTH_BITS) != '0;
   assign ratio   = state_ff == ST_SCALE;

   assign div_rem_init = ratio ? REM_W'(prod[PROD_W-1:INDEX_BITS])
                               : REM_W'(avg_num[NUM_W-1:AVG_W]);
   assign div_quo_init = ratio ? {prod[INDEX_BITS-1:0], {(AVG_W-INDEX_BITS){1'b0}}}
                               : avg_num[AVG_W-1:0];
   assign div_den      = ratio ? den_sum : REM_W'(p);

   always_comb begin
      div_ctl.start = (state_ff == ST_GAIN_LOAD) || (state_ff == ST_LOSS_LOAD)
                      || (ratio && !big && (sl_ff != '0));
      div_ctl.steps = ratio ? RATIO_STEPS : STEP_BITS'(AVG_W);
   end

   rsi_div #(
      .REM_W (REM_W),
      .QUO_W (AVG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .rem_init (div_rem_init),
      .quo_init (div_quo_init),
      .den      (div_den),
      .quo      (div_quo),
      .done     (div_done)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (first || (seen_ff < p_seen)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_GAIN_LOAD;
               end
            end
         end
         ST_GAIN_LOAD: begin
            state_in = ST_GAIN_DIV;
         end
         ST_GAIN_DIV: begin
            if (div_done) begin
               state_in = ST_LOSS_LOAD;
            end
         end
         ST_LOSS_LOAD: begin
            state_in = ST_LOSS_DIV;
         end
         ST_LOSS_DIV: begin
            if (div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (!big) begin
               state_in = (sl_ff == '0) ? ST_RESP : ST_RATIO_DIV;
            end
         end
         ST_RATIO_DIV: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      period_in          = period_ff;
      prev_in            = prev_ff;
      seen_in            = seen_ff;
      gain_avg_in        = gain_avg_ff;
      loss_avg_in        = loss_avg_ff;
      gain_in            = gain_ff;
      loss_in            = loss_ff;
      smooth_in          = smooth_ff;
      sg_in              = sg_ff;
      sl_in              = sl_ff;
      res_in             = res_ff;
      resv_in            = resv_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_strength_in    = rsp_strength_ff;
      rsp_index_valid_in = rsp_index_valid_ff;

      if (csr_valid && csr_ready) begin
         period_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               prev_in = req_price;
               res_in  = '0;
               resv_in = 1'b0;
               if (first) begin
                  seen_in     = SEEN_BITS'(1);
                  gain_avg_in = '0;
                  loss_avg_in = '0;
               end else begin
                  if (seen_ff < SEEN_MAX) begin
                     seen_in = seen_ff + SEEN_BITS'(1);
                  end
                  gain_in = gain_new;
                  loss_in = loss_new;
                  if (seen_ff < p_seen) begin
                     gain_avg_in = gain_avg_ff + AVG_W'(gain_new);
                     loss_avg_in = loss_avg_ff + AVG_W'(loss_new);
                  end else begin
                     smooth_in = seen_ff != p_seen;
                  end
               end
            end
         end
         ST_GAIN_DIV: begin
            if (div_done) begin
               gain_avg_in = div_quo;
            end
         end
         ST_LOSS_DIV: begin
            if (div_done) begin
               loss_avg_in = div_quo;
               sg_in       = gain_avg_ff;
               sl_in       = div_quo;
            end
         end
         ST_SCALE: begin
            if (big) begin
               sg_in = sg_ff >> 1;
               sl_in = sl_ff >> 1;
            end else if (sl_ff == '0) begin
               res_in  = FULL_SCALE;
               resv_in = 1'b1;
            end
         end
         ST_RATIO_DIV: begin
            if (div_done) begin
               res_in  = div_quo[INDEX_BITS-1:0];
               resv_in = 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in       = 1'b1;
               rsp_strength_in    = res_ff;
               rsp_index_valid_in = resv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prev_ff            <= prev_in;
      gain_avg_ff        <= gain_avg_in;
      loss_avg_ff        <= loss_avg_in;
      gain_ff            <= gain_in;
      loss_ff            <= loss_in;
      smooth_ff          <= smooth_in;
      sg_ff              <= sg_in;
      sl_ff              <= sl_in;
      res_ff             <= res_in;
      resv_ff            <= resv_in;
      rsp_strength_ff    <= rsp_strength_in;
      rsp_index_valid_ff <= rsp_index_valid_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign csr_ready          = state_ff == ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_strength_index = rsp_strength_ff;
   assign rsp_index_valid    = rsp_index_valid_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_index_valid |-> rsp_strength_index == '0)
      else $error("invalid response carries a nonzero index");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_strength_index <= FULL_SCALE)
      else $error("strength index above full scale");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_GAIN_DIV) || (state_ff == ST_LOSS_DIV)
                   || (state_ff == ST_RATIO_DIV))
      else $error("divider finished outside a divide state");

   a_start_short: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_series_start |=> state_ff == ST_RESP)
      else $error("series start request did not go straight to response");

endmodule
